@@ hw/rtl/gif_lzw_pkg.sv @@
// shared types and constants of the gif lzw decoder
`timescale 1ns / 1ps
`default_nettype none
package gif_lzw_pkg;

	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 23;
	localparam int STATUS_W = 2;
	localparam int MODE_W   = 2;
	localparam int BUF_W    = 32;
	localparam int HELD_W   = 6;
	localparam int SIZE_W   = 4;
	localparam int MIN_SIZE = 2;
	localparam int MAX_SIZE = 8;
	localparam int SIZE_RESET = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_BYTE  = 2'd0,
		MODE_PIXEL = 2'd1,
		MODE_FRAME = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_RUN     = 2'd0,
		STAT_DONE    = 2'd1,
		STAT_SHORT   = 2'd2,
		STAT_CORRUPT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_DECODE = 2'd0,
		PH_DRAIN  = 2'd1,
		PH_DONE   = 2'd2,
		PH_ENDED  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOP,
		ST_POPD,
		ST_KK,
		ST_WALK,
		ST_ROOT,
		ST_RESP
	} state_t;

	localparam logic [0:0] REG_MIN_SIZE = 1'b0;
	localparam logic [0:0] REG_PIXELS   = 1'b1;

endpackage
`default_nettype wire

@@ hw/rtl/gif_lzw_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module gif_lzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ hw/rtl/gif_lzw_decoder.sv @@
// gif image-data lzw decoder top level
// Input channel (in_valid/in_stall) carries mode and data_byte; each accepted
// transfer gives exactly one result transfer on the output channel
// (out_valid/out_stall) with accepted, pixel_valid, pixel_index, last_pixel,
// status. The apb port holds min_code_size (0x0) and pixel_count (0x4).
// Items are handled one at a time: an input transfer is taken only in the idle
// state. Byte offers, frame starts and mode 3 go from idle to the response
// state, which loads the output register; the next input transfer can follow
// once the block is back in idle. A pixel request that pops a held string
// entry passes the loop, pop and response states. When the string stack is
// empty, decoding a code takes the loop state for the code, one walk step per
// string character (prefix/suffix table walk, one ram read per cycle) and the
// root state to close the entry; a K+K code adds the K+K state, and a clear
// code or dropping a string beyond pixel_count is each handled in a loop pass.
// The result sits in an output register; while the receiver stalls, the block
// keeps the next result waiting and takes no new input.
// Reset (arst_n low) returns all control state to its start of frame values,
// min_code_size to 8 and pixel_count to 0; the table and stack rams are not
// cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module gif_lzw_decoder
	import gif_lzw_pkg::*;
#(
	parameter int MAX_CODE_BITS = 12,
	parameter int STACK_DEPTH   = 4096
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [MODE_W-1:0]   mode,
	input  wire logic [BYTE_W-1:0]   data_byte,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     accepted,
	output logic                     pixel_valid,
	output logic      [BYTE_W-1:0]   pixel_index,
	output logic                     last_pixel,
	output logic      [STATUS_W-1:0] status
);

	localparam int CW   = MAX_CODE_BITS;
	localparam int NW   = MAX_CODE_BITS + 1;
	localparam int TABLE_SIZE = 1 << MAX_CODE_BITS;
	localparam int SW   = $clog2(STACK_DEPTH) + 1;
	localparam int SAW  = $clog2(STACK_DEPTH);
	localparam int WW   = $clog2(MAX_CODE_BITS + 1);

	logic [SIZE_W-1:0]  min_size_q;
	logic [COUNT_W-1:0] pix_count_q;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic [SW-1:0]       sp_q, sp_d;
	logic [BUF_W-1:0]    buf_q, buf_d;
	logic [HELD_W-1:0]   held_q, held_d;
	logic [BYTE_W-1:0]   sbl_q, sbl_d;
	logic [WW-1:0]       cw_q, cw_d;
	logic [NW-1:0]       nfc_q, nfc_d;
	logic [CW-1:0]       prev_q, prev_d;
	logic                prev_ok_q, prev_ok_d;
	logic [BYTE_W-1:0]   prev_first_q, prev_first_d;
	logic [COUNT_W-1:0]  emitted_q, emitted_d;
	logic [STATUS_W-1:0] fst_q, fst_d;
	logic [CW-1:0]       code_q, code_d;
	logic [CW-1:0]       w_q, w_d;
	logic                first_q, first_d;
	logic [BYTE_W-1:0]   root_q, root_d;
	logic                res_acc_q, res_acc_d;
	logic                res_pv_q, res_pv_d;
	logic [BYTE_W-1:0]   res_pix_q, res_pix_d;
	logic                res_last_q, res_last_d;
	logic                out_load;

	logic                tbl_we;
	logic [CW-1:0]       tbl_raddr;
	logic [CW-1:0]       pre_rdata;
	logic [BYTE_W-1:0]   sfx_rdata;
	logic                stk_we;
	logic [SAW-1:0]      stk_waddr, stk_raddr;
	logic [BYTE_W-1:0]   stk_wdata, stk_rdata;

	logic [SIZE_W-1:0]   eff_size;
	logic [NW-1:0]       clr, root;
	logic [NW-1:0]       code_mask;
	logic [CW-1:0]       code_now;
	logic [NW-1:0]       cur;
	logic [NW-1:0]       nfc_inc;
	logic                cfg_we;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	always_comb begin
		unique case (paddr[2])
			REG_MIN_SIZE: prdata = {{(32-SIZE_W){1'b0}}, min_size_q};
			REG_PIXELS:   prdata = {{(32-COUNT_W){1'b0}}, pix_count_q};
			default:      prdata = '0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_size_q  <= SIZE_W'(SIZE_RESET);
			pix_count_q <= '0;
		end else if (cfg_we) begin
			if (paddr[2] == REG_MIN_SIZE) min_size_q <= pwdata[SIZE_W-1:0];
			else pix_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		if (min_size_q < SIZE_W'(MIN_SIZE)) eff_size = SIZE_W'(MIN_SIZE);
		else if (min_size_q > SIZE_W'(MAX_SIZE)) eff_size = SIZE_W'(MAX_SIZE);
		else eff_size = min_size_q;
	end
	assign clr       = NW'(1) << eff_size;
	assign root      = clr + NW'(2);
	assign code_mask = (NW'(1) << cw_q) - NW'(1);
	assign code_now  = buf_q[CW-1:0] & code_mask[CW-1:0];
	assign cur       = first_q ? {1'b0, w_q} : {1'b0, pre_rdata};
	assign nfc_inc   = nfc_q + NW'(1);

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		sp_d         = sp_q;
		buf_d        = buf_q;
		held_d       = held_q;
		sbl_d        = sbl_q;
		cw_d         = cw_q;
		nfc_d        = nfc_q;
		prev_d       = prev_q;
		prev_ok_d    = prev_ok_q;
		prev_first_d = prev_first_q;
		emitted_d    = emitted_q;
		fst_d        = fst_q;
		code_d       = code_q;
		w_d          = w_q;
		first_d      = first_q;
		root_d       = root_q;
		res_acc_d    = res_acc_q;
		res_pv_d     = res_pv_q;
		res_pix_d    = res_pix_q;
		res_last_d   = res_last_q;
		out_load     = 1'b0;
		tbl_we       = 1'b0;
		tbl_raddr    = cur[CW-1:0];
		stk_we       = 1'b0;
		stk_waddr    = sp_q[SAW-1:0];
		stk_wdata    = root_q;
		stk_raddr    = SAW'(sp_q - SW'(1));

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					res_acc_d  = 1'b0;
					res_pv_d   = 1'b0;
					res_pix_d  = '0;
					res_last_d = 1'b0;
					state_d    = ST_RESP;
					unique case (mode_t'(mode))
						MODE_BYTE: begin
							res_acc_d = 1'b1;
							if (phase_q == PH_DECODE) begin
								if (sbl_q == '0) begin
									if (data_byte == '0) phase_d = PH_ENDED;
									else sbl_d = data_byte;
								end else if (held_q <= HELD_W'(24)) begin
									buf_d  = buf_q | ({{(BUF_W-BYTE_W){1'b0}}, data_byte}
										<< held_q[4:0]);
									held_d = held_q + HELD_W'(8);
									sbl_d  = sbl_q - BYTE_W'(1);
								end else begin
									res_acc_d = 1'b0;
								end
							end else if (phase_q == PH_DRAIN) begin
								if (sbl_q == '0) begin
									if (data_byte == '0) phase_d = PH_DONE;
									else sbl_d = data_byte;
								end else begin
									sbl_d = sbl_q - BYTE_W'(1);
								end
							end
						end
						MODE_PIXEL: state_d = ST_LOOP;
						MODE_FRAME: begin
							sp_d      = '0;
							buf_d     = '0;
							held_d    = '0;
							sbl_d     = '0;
							cw_d      = WW'(eff_size) + WW'(1);
							nfc_d     = root;
							prev_d    = '0;
							prev_ok_d = 1'b0;
							emitted_d = '0;
							phase_d   = PH_DECODE;
							fst_d     = STAT_RUN;
						end
						MODE_NONE: ;
						default: ;
					endcase
				end
			end
			ST_LOOP: begin
				if (sp_q != '0) begin
					if (emitted_q < pix_count_q) begin
						sp_d       = sp_q - SW'(1);
						emitted_d  = emitted_q + COUNT_W'(1);
						res_pv_d   = 1'b1;
						res_last_d = (emitted_d == pix_count_q);
						state_d    = ST_POPD;
					end else begin
						sp_d = '0;
					end
				end else if (phase_q != PH_DECODE && phase_q != PH_ENDED) begin
					state_d = ST_RESP;
				end else if (held_q < HELD_W'(cw_q)) begin
					if (phase_q == PH_ENDED) begin
						fst_d   = (emitted_q >= pix_count_q) ? STAT_DONE : STAT_SHORT;
						phase_d = PH_DONE;
						buf_d   = '0;
						held_d  = '0;
					end
					state_d = ST_RESP;
				end else begin
					buf_d  = buf_q >> cw_q;
					held_d = held_q - HELD_W'(cw_q);
					code_d = code_now;
					if ({1'b0, code_now} == clr) begin
						cw_d      = WW'(eff_size) + WW'(1);
						nfc_d     = root;
						prev_ok_d = 1'b0;
					end else if ({1'b0, code_now} == clr + NW'(1)) begin
						fst_d   = (emitted_q >= pix_count_q) ? STAT_DONE : STAT_SHORT;
						phase_d = (phase_q == PH_ENDED) ? PH_DONE : PH_DRAIN;
						buf_d   = '0;
						held_d  = '0;
						state_d = ST_RESP;
					end else if ({1'b0, code_now} < nfc_q) begin
						w_d     = code_now;
						first_d = 1'b1;
						state_d = ST_WALK;
					end else if ({1'b0, code_now} == nfc_q && prev_ok_q) begin
						state_d = ST_KK;
					end else begin
						fst_d   = STAT_CORRUPT;
						phase_d = (phase_q == PH_ENDED) ? PH_DONE : PH_DRAIN;
						buf_d   = '0;
						held_d  = '0;
						state_d = ST_RESP;
					end
				end
			end
			ST_POPD: begin
				res_pix_d = stk_rdata;
				state_d   = ST_RESP;
			end
			ST_KK: begin
				stk_we    = 1'b1;
				stk_wdata = prev_first_q;
				sp_d      = sp_q + SW'(1);
				w_d       = prev_q;
				first_d   = 1'b1;
				state_d   = ST_WALK;
			end
			ST_WALK: begin
				if (!first_q) begin
					stk_we    = 1'b1;
					stk_wdata = sfx_rdata;
					sp_d      = sp_q + SW'(1);
				end
				first_d = 1'b0;
				if (cur >= root) begin
					tbl_raddr = cur[CW-1:0];
				end else begin
					root_d  = cur[BYTE_W-1:0];
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				stk_we    = 1'b1;
				stk_wdata = root_q;
				sp_d      = sp_q + SW'(1);
				if (prev_ok_q && nfc_q < NW'(TABLE_SIZE)) begin
					tbl_we = 1'b1;
					nfc_d  = nfc_inc;
				end
				prev_first_d = root_q;
				prev_d       = code_q;
				prev_ok_d    = 1'b1;
				if (cw_q < WW'(MAX_CODE_BITS) && nfc_d == (NW'(1) << cw_q)) begin
					cw_d = cw_q + WW'(1);
				end
				state_d = ST_LOOP;
			end
			ST_RESP: begin
				if (!out_valid || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_DECODE;
			sp_q         <= '0;
			buf_q        <= '0;
			held_q       <= '0;
			sbl_q        <= '0;
			cw_q         <= WW'(SIZE_RESET + 1);
			nfc_q        <= NW'((1 << SIZE_RESET) + 2);
			prev_q       <= '0;
			prev_ok_q    <= 1'b0;
			emitted_q    <= '0;
			fst_q        <= STAT_RUN;
			out_valid    <= 1'b0;
		end else begin
			state_q      <= state_d;
			phase_q      <= phase_d;
			sp_q         <= sp_d;
			buf_q        <= buf_d;
			held_q       <= held_d;
			sbl_q        <= sbl_d;
			cw_q         <= cw_d;
			nfc_q        <= nfc_d;
			prev_q       <= prev_d;
			prev_ok_q    <= prev_ok_d;
			emitted_q    <= emitted_d;
			fst_q        <= fst_d;
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prev_first_q <= prev_first_d;
		code_q       <= code_d;
		w_q          <= w_d;
		first_q      <= first_d;
		root_q       <= root_d;
		res_acc_q    <= res_acc_d;
		res_pv_q     <= res_pv_d;
		res_pix_q    <= res_pix_d;
		res_last_q   <= res_last_d;
		if (out_load) begin
			accepted    <= res_acc_q;
			pixel_valid <= res_pv_q;
			pixel_index <= res_pix_q;
			last_pixel  <= res_last_q;
			status      <= fst_q;
		end
	end

	gif_lzw_ram #(.WIDTH(CW), .DEPTH(TABLE_SIZE)) u_prefix (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (nfc_q[CW-1:0]),
		.wdata (prev_q),
		.raddr (tbl_raddr),
		.rdata (pre_rdata)
	);

	gif_lzw_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_suffix (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (nfc_q[CW-1:0]),
		.wdata (root_q),
		.raddr (tbl_raddr),
		.rdata (sfx_rdata)
	);

	gif_lzw_ram #(.WIDTH(BYTE_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SW'(STACK_DEPTH))
		else $error("string stack pointer beyond depth");

	a_table_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nfc_q <= NW'(TABLE_SIZE) && cw_q <= WW'(MAX_CODE_BITS))
		else $error("code table or code width out of range");

	a_last_has_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res_last_q |-> res_pv_q)
		else $error("last pixel flagged without a pixel");

	a_pop_follows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POPD |-> $past(state_q) == ST_LOOP && $past(sp_q) != '0)
		else $error("stack pop without a held entry");

endmodule
`default_nettype wire

@@ verif/tb_gif_lzw_decoder.sv @@
// self-checking testbench of the gif lzw decoder: lzw-encoded frames, corrupt and noisy streams
`timescale 1ns / 1ps
module tb_gif_lzw_decoder;
	import gif_lzw_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int TBL = 4096;
	localparam int ENC_NORMAL = 0;
	localparam int ENC_NO_END = 1;
	localparam int ENC_CORRUPT_ABOVE = 2;
	localparam int ENC_CORRUPT_EQUAL = 3;
	localparam logic [2:0] ADDR_MIN_SIZE = 3'(4 * REG_MIN_SIZE);
	localparam logic [2:0] ADDR_PIXELS = 3'(4 * REG_PIXELS);

	typedef struct packed {
		logic        acc;
		logic        valid;
		logic [7:0]  pix;
		logic        last;
		status_t     st;
	} pixel_result_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [MODE_W-1:0] mode;
	logic [7:0] data_byte;
	logic accepted, pixel_valid, last_pixel;
	logic [7:0] pixel_index;
	logic [STATUS_W-1:0] status;

	gif_lzw_decoder dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
		.pixel_valid(pixel_valid), .pixel_index(pixel_index), .last_pixel(last_pixel),
		.status(status)
	);

	pixel_result_t expected_pixels[$];
	int errors = 0;
	int cycles = 0;
	int items_sent = 0;
	bit no_idle = 0;

	// decoder shadow state
	logic [3:0]  sh_min_size;
	logic [22:0] sh_pixel_count;
	logic [11:0] sh_prefix[TBL];
	logic [7:0]  sh_suffix[TBL];
	logic [7:0]  sh_stack[TBL];
	int unsigned sh_sp, sh_buf, sh_held, sh_left, sh_width, sh_next, sh_prev;
	bit          sh_prev_ok;
	int unsigned sh_emitted;
	phase_t      sh_phase;
	status_t     sh_final;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 30);
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		pixel_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result transfer");
			end else begin
				e = expected_pixels.pop_front();
				if (e.acc !== accepted || e.valid !== pixel_valid || e.pix !== pixel_index ||
						e.last !== last_pixel || e.st !== status) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp acc %0d val %0d pix %0d last %0d st %0d,",
							e.acc, e.valid, e.pix, e.last, e.st,
							" got %0d %0d %0d %0d %0d",
							accepted, pixel_valid, pixel_index, last_pixel, status);
				end
			end
		end
	end

	function automatic int unsigned eff_size();
		if (sh_min_size < 2) return 2;
		if (sh_min_size > 8) return 8;
		return sh_min_size;
	endfunction

	function automatic void frame_restart();
		sh_sp = 0; sh_buf = 0; sh_held = 0; sh_left = 0;
		sh_width = eff_size() + 1;
		sh_next = (1 << eff_size()) + 2;
		sh_prev = 0; sh_prev_ok = 0; sh_emitted = 0;
		sh_phase = PH_DECODE; sh_final = STAT_RUN;
	endfunction

	function automatic logic [7:0] root_of(int unsigned c);
		int unsigned root, guard;
		root = (1 << eff_size()) + 2;
		guard = 0;
		while (c >= root && c < TBL && guard < TBL) begin
			c = sh_prefix[c];
			guard++;
		end
		return c[7:0];
	endfunction

	function automatic void stack_string(int unsigned c);
		int unsigned root;
		root = (1 << eff_size()) + 2;
		while (c >= root && c < TBL && sh_sp < TBL) begin
			sh_stack[sh_sp] = sh_suffix[c];
			sh_sp++;
			c = sh_prefix[c];
		end
		if (sh_sp < TBL) begin
			sh_stack[sh_sp] = c[7:0];
			sh_sp++;
		end
	endfunction

	function automatic void end_decode(status_t s);
		sh_final = s;
		sh_phase = (sh_phase == PH_ENDED) ? PH_DONE : PH_DRAIN;
		sh_buf = 0;
		sh_held = 0;
	endfunction

	function automatic status_t end_status();
		return (sh_emitted >= sh_pixel_count) ? STAT_DONE : STAT_SHORT;
	endfunction

	function automatic bit decode_code();
		int unsigned clr, code;
		logic [7:0] f;
		clr = 1 << eff_size();
		if (sh_held < sh_width) begin
			if (sh_phase == PH_ENDED) end_decode(end_status());
			return 0;
		end
		code = sh_buf & ((1 << sh_width) - 1);
		sh_buf = sh_buf >> sh_width;
		sh_held -= sh_width;
		if (code == clr) begin
			sh_width = eff_size() + 1;
			sh_next = clr + 2;
			sh_prev_ok = 0;
			return 1;
		end
		if (code == clr + 1) begin
			end_decode(end_status());
			return 0;
		end
		if (code < sh_next) begin
			stack_string(code);
			if (sh_prev_ok && sh_next < TBL) begin
				sh_prefix[sh_next] = sh_prev[11:0];
				sh_suffix[sh_next] = sh_stack[sh_sp - 1];
				sh_next++;
			end
		end else if (code == sh_next && sh_prev_ok) begin
			f = root_of(sh_prev);
			if (sh_sp < TBL) begin
				sh_stack[sh_sp] = f;
				sh_sp++;
			end
			stack_string(sh_prev);
			if (sh_next < TBL) begin
				sh_prefix[sh_next] = sh_prev[11:0];
				sh_suffix[sh_next] = f;
				sh_next++;
			end
		end else begin
			end_decode(STAT_CORRUPT);
			return 0;
		end
		sh_prev = code;
		sh_prev_ok = 1;
		if (sh_width < 12 && sh_next == (1 << sh_width)) sh_width++;
		return 1;
	endfunction

	function automatic pixel_result_t decode_item(mode_t m, logic [7:0] b);
		pixel_result_t r;
		r = '0;
		if (m == MODE_BYTE) begin
			r.acc = 1;
			if (sh_phase == PH_DECODE) begin
				if (sh_left == 0) begin
					if (b == 0) sh_phase = PH_ENDED;
					else sh_left = b;
				end else if (sh_held <= 24) begin
					sh_buf = sh_buf | (32'(b) << sh_held);
					sh_held += 8;
					sh_left--;
				end else r.acc = 0;
			end else if (sh_phase == PH_DRAIN) begin
				if (sh_left == 0) begin
					if (b == 0) sh_phase = PH_DONE;
					else sh_left = b;
				end else sh_left--;
			end
		end else if (m == MODE_PIXEL) begin
			while (1'b1) begin
				if (sh_sp > 0) begin
					if (sh_emitted < sh_pixel_count) begin
						sh_sp--;
						r.pix = sh_stack[sh_sp];
						sh_emitted++;
						r.valid = 1;
						r.last = (sh_emitted == sh_pixel_count);
						break;
					end
					sh_sp = 0;
				end
				if (sh_phase != PH_DECODE && sh_phase != PH_ENDED) break;
				if (!decode_code()) break;
			end
		end else if (m == MODE_FRAME) frame_restart();
		r.st = sh_final;
		return r;
	endfunction

	task automatic send_item(input mode_t m, input logic [7:0] b, output pixel_result_t r);
		bit free;
		if (!no_idle && $urandom_range(99) < 30) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		mode <= m;
		data_byte <= b;
		do begin
			@(negedge clk);
			free = !in_stall;
			@(posedge clk);
		end while (!free);
		r = decode_item(m, b);
		expected_pixels.push_back(r);
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] a, input logic [31:0] v);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= a; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (a == ADDR_MIN_SIZE) sh_min_size = v[3:0];
		else sh_pixel_count = v[22:0];
	endtask

	// gif lzw encoder with the same early width change as the decoder
	task automatic lzw_encode(input int unsigned s, input logic [7:0] pix[$], input int clr_every,
			input int enc_kind, input int max_block, output logic [7:0] stream[$]);
		int dict[int];
		int unsigned clr, enc_next, dec_next, width, w, nbits, i, blk;
		bit fresh;
		longint unsigned acc;
		logic [7:0] packed_bytes[$];
		clr = 1 << s;
		acc = 0; nbits = 0;
		stream = {};
		begin
			// emit clear first
			dict.delete();
			enc_next = clr + 2; dec_next = clr + 2; width = s + 1; fresh = 1;
			acc |= longint'(clr) << nbits; nbits += width;
			if (enc_kind == ENC_CORRUPT_ABOVE || enc_kind == ENC_CORRUPT_EQUAL) begin
				acc |= longint'(enc_kind == ENC_CORRUPT_ABOVE ? (1 << width) - 1 : clr + 2) << nbits;
				nbits += width;
			end
			w = pix[0];
			for (i = 1; i <= pix.size(); i++) begin
				if (i < pix.size() && dict.exists(w * 256 + pix[i])) begin
					w = dict[w * 256 + pix[i]];
					continue;
				end
				acc |= longint'(w) << nbits; nbits += width;
				if (!fresh && dec_next < TBL) dec_next++;
				fresh = 0;
				if (width < 12 && dec_next == (1 << width)) width++;
				while (nbits >= 8) begin
					packed_bytes.push_back(acc[7:0]);
					acc >>= 8; nbits -= 8;
				end
				if (i == pix.size()) break;
				if (clr_every != 0 && i % clr_every == 0) begin
					acc |= longint'(clr) << nbits; nbits += width;
					dict.delete();
					enc_next = clr + 2; dec_next = clr + 2; width = s + 1; fresh = 1;
				end else if (enc_next < TBL) begin
					dict[w * 256 + pix[i]] = enc_next;
					enc_next++;
				end
				w = pix[i];
			end
			if (enc_kind == ENC_NORMAL) begin
				acc |= longint'(clr + 1) << nbits; nbits += width;
			end
			while (nbits > 0) begin
				packed_bytes.push_back(acc[7:0]);
				acc >>= 8; nbits = (nbits > 8) ? nbits - 8 : 0;
			end
		end
		while (packed_bytes.size() > 0) begin
			blk = $urandom_range(1, max_block);
			if (blk > packed_bytes.size()) blk = packed_bytes.size();
			stream.push_back(blk[7:0]);
			repeat (blk) stream.push_back(packed_bytes.pop_front());
		end
		stream.push_back(8'd0);
	endtask

	// configure, start a frame, then interleave byte offers and pixel pulls
	task automatic run_frame(input logic [31:0] size, input logic [31:0] count,
			input logic [7:0] stream[$], input int pull_pct);
		pixel_result_t r;
		int idx, pulls;
		wait_idle();
		apb_write(ADDR_MIN_SIZE, size);
		apb_write(ADDR_PIXELS, count);
		send_item(MODE_FRAME, $urandom, r);
		idx = 0;
		while (idx < stream.size()) begin
			if ($urandom_range(59) == 0) send_item(MODE_NONE, $urandom, r);
			if ($urandom_range(99) < pull_pct) send_item(MODE_PIXEL, $urandom, r);
			else begin
				send_item(MODE_BYTE, stream[idx], r);
				if (r.acc) idx++;
				else send_item(MODE_PIXEL, $urandom, r);
			end
		end
		pulls = 0;
		do begin
			send_item(MODE_PIXEL, $urandom, r);
			pulls++;
		end while ((r.valid || r.st == STAT_RUN) && pulls < 300);
		repeat ($urandom_range(0, 3)) send_item(MODE_BYTE, $urandom, r);
	endtask

	function automatic void random_pixels(int unsigned s, int n, int run_bias,
			ref logic [7:0] pix[$]);
		pix = {};
		for (int i = 0; i < n; i++)
			if (i > 0 && $urandom_range(99) < run_bias) pix.push_back(pix[i - 1]);
			else pix.push_back(8'($urandom_range(0, (1 << s) - 1)));
	endfunction

	task automatic test_after_reset();
		pixel_result_t r;
		send_item(MODE_PIXEL, 8'hff, r);
		send_item(MODE_NONE, 8'h00, r);
		send_item(MODE_BYTE, 8'h02, r);
	endtask

	task automatic test_size_extremes();
		logic [7:0] pix[$], s[$];
		random_pixels(2, 30, 20, pix);
		lzw_encode(2, pix, 0, ENC_NORMAL, 255, s);
		run_frame(2, 30, s, 50);
		pix = {8'd0, 8'd255, 8'd255, 8'd0, 8'd170, 8'd85};
		lzw_encode(8, pix, 0, ENC_NORMAL, 3, s);
		run_frame(15, 6, s, 40);
		random_pixels(2, 12, 30, pix);
		lzw_encode(2, pix, 5, ENC_NORMAL, 4, s);
		run_frame(0, 12, s, 40);
	endtask

	task automatic test_repeated_strings();
		logic [7:0] pix[$], s[$];
		pix = {};
		repeat (40) pix.push_back(8'd3);
		lzw_encode(4, pix, 0, ENC_NORMAL, 8, s);
		run_frame(4, 40, s, 50);
	endtask

	task automatic test_pixel_counts();
		logic [7:0] pix[$], s[$];
		random_pixels(3, 20, 40, pix);
		lzw_encode(3, pix, 0, ENC_NORMAL, 6, s);
		run_frame(3, 8, s, 50);
		run_frame(3, 0, s, 50);
		run_frame(3, 23'h7fffff, s, 50);
		run_frame(3, 4194304, s, 50);
	endtask

	task automatic test_bad_streams();
		logic [7:0] pix[$], s[$];
		random_pixels(5, 10, 20, pix);
		lzw_encode(5, pix, 0, ENC_CORRUPT_ABOVE, 5, s);
		run_frame(5, 10, s, 30);
		lzw_encode(6, pix, 0, ENC_CORRUPT_EQUAL, 5, s);
		run_frame(6, 10, s, 30);
		lzw_encode(5, pix, 0, ENC_NO_END, 5, s);
		run_frame(5, 10, s, 30);
	endtask

	task automatic test_full_buffer();
		logic [7:0] pix[$], s[$];
		random_pixels(7, 16, 10, pix);
		lzw_encode(7, pix, 0, ENC_NORMAL, 20, s);
		run_frame(7, 16, s, 0);
	endtask

	task automatic test_random_frames();
		logic [7:0] pix[$], s[$];
		int unsigned sz, n, cnt, kind, roll;
		int start;
		start = items_sent;
		while (items_sent - start < 200) begin
			// first stretch runs with no idling on either side
			no_idle = ((items_sent - start) < 60);
			sz = $urandom_range(2, 8);
			n = $urandom_range(1, 50);
			roll = $urandom_range(99);
			cnt = (roll < 60) ? n : $urandom_range(0, n + 10);
			kind = ENC_NORMAL;
			roll = $urandom_range(99);
			if (roll < 5) kind = ENC_NO_END;
			else if (roll < 8) kind = ENC_CORRUPT_ABOVE;
			else if (roll < 10) kind = ENC_CORRUPT_EQUAL;
			random_pixels(sz, n, $urandom_range(0, 80), pix);
			lzw_encode(sz, pix, ($urandom_range(4) == 0) ? $urandom_range(2, 10) : 0, kind,
				$urandom_range(1, 30), s);
			if ($urandom_range(9) == 0) begin
				// noise stream
				s = {};
				repeat ($urandom_range(2, 20)) s.push_back(8'($urandom));
				s.push_back(8'd0);
			end
			run_frame(sz, cnt, s, $urandom_range(10, 60));
		end
		no_idle = 0;
	endtask

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_valid = 0; mode = MODE_NONE; data_byte = '0;
		sh_min_size = SIZE_RESET;
		sh_pixel_count = '0;
		frame_restart();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_after_reset();
		test_size_extremes();
		test_repeated_strings();
		test_pixel_counts();
		test_bad_streams();
		test_full_buffer();
		test_random_frames();
		wait_idle();
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/gif_lzw_pkg.sv
hw/rtl/gif_lzw_ram.sv
hw/rtl/gif_lzw_decoder.sv
verif/tb_gif_lzw_decoder.sv
